// ----- rtl/stereo_feedback_delay_macros.svh -----
// assertion macros for the stereo feedback delay
`ifndef STEREO_FEEDBACK_DELAY_MACROS_SVH
`define STEREO_FEEDBACK_DELAY_MACROS_SVH

// same-cycle implication
`define SFD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfd assertion failed");

// next-cycle implication
`define SFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfd assertion failed");

`endif

// ----- rtl/sfd_pkg.sv -----
// shared constants, types and arithmetic helpers of the stereo feedback delay
package sfd_pkg;

   localparam int LINE_DEPTH = 131072;
   localparam int CHANNELS   = 2;
   localparam int SAMPLE_W   = 16;
   localparam int PTR_W      = $clog2(LINE_DEPTH);
   localparam int DELAY_W    = 17;
   localparam int FB_W       = 15;
   localparam int MIX_W      = 16;
   localparam int REG_IDX_W  = 2;
   localparam int CALC_W     = ((PTR_W > DELAY_W) ? PTR_W : DELAY_W) + 1;
   localparam int WORD_W     = CHANNELS * SAMPLE_W;
   localparam int BUS_W      = 2 * SAMPLE_W;
   localparam int ACC_W      = 34;

   localparam logic [MIX_W-1:0]   MIX_ONE       = MIX_W'(32768);
   localparam logic [DELAY_W-1:0] DELAY_RESET   = DELAY_W'(24000);
   localparam logic [FB_W-1:0]    FB_RESET      = FB_W'(16384);
   localparam logic [MIX_W-1:0]   MIX_RESET     = MIX_W'(16384);
   localparam logic [PTR_W-1:0]   LAST_PTR      = PTR_W'(LINE_DEPTH - 1);

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_DELAY    = 2'd0,
      REG_FEEDBACK = 2'd1,
      REG_MIX      = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [FB_W-1:0]  fb_gain;
      logic [MIX_W-1:0] mix;
   } gain_type;

   // add half an lsb, floor shift by 15, clamp to 16 bits
   function automatic sample_type round_sat(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] r;
      logic signed [ACC_W-1:0] q;
      r = x + $signed(ACC_W'(16384));
      q = r >>> 15;
      if (q > $signed(ACC_W'(32767))) begin
         return sample_type'(16'sh7fff);
      end else if (q < -$signed(ACC_W'(32768))) begin
         return sample_type'(16'sh8000);
      end else begin
         return sample_type'(q[SAMPLE_W-1:0]);
      end
   endfunction

   function automatic sample_type sat_add(input sample_type a, input sample_type b);
      logic signed [SAMPLE_W:0] s;
      s = (SAMPLE_W+1)'(a) + (SAMPLE_W+1)'(b);
      if (s[SAMPLE_W] != s[SAMPLE_W-1]) begin
         return s[SAMPLE_W] ? sample_type'(16'sh8000) : sample_type'(16'sh7fff);
      end else begin
         return sample_type'(s[SAMPLE_W-1:0]);
      end
   endfunction

endpackage

// ----- rtl/sfd_ram.sv -----
// simple dual-port ram, one write and one registered read per cycle
module sfd_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sfd_lane.sv -----
// per-channel datapath: registered products, then rounding, saturation and feedback sum
module sfd_lane (
   input  logic                clock,
   input  logic                load,
   input  sfd_pkg::sample_type dry,
   input  sfd_pkg::sample_type del,
   input  sfd_pkg::gain_type   gain,
   output sfd_pkg::sample_type wr_data,
   output sfd_pkg::sample_type y
);
   import sfd_pkg::*;

   logic signed [ACC_W-1:0] fb_prod_ff;
   logic signed [ACC_W-1:0] dry_prod_ff;
   logic signed [ACC_W-1:0] wet_prod_ff;
   sample_type              dry_ff;

   logic signed [ACC_W-1:0] del_x;
   logic signed [ACC_W-1:0] dry_x;
   logic signed [ACC_W-1:0] fb_x;
   logic signed [ACC_W-1:0] wet_x;
   logic signed [ACC_W-1:0] dw_x;
   logic        [MIX_W:0]   dry_weight;
   sample_type              fb_term;

   always_comb begin
      dry_weight = (MIX_W+1)'(MIX_ONE) - (MIX_W+1)'(gain.mix);
      del_x      = ACC_W'(del);
      dry_x      = ACC_W'(dry);
      fb_x       = $signed(ACC_W'(gain.fb_gain));
      wet_x      = $signed(ACC_W'(gain.mix));
      dw_x       = $signed(ACC_W'(dry_weight));
   end

   always_ff @(posedge clock) begin
      if (load) begin
         fb_prod_ff  <= del_x * fb_x;
         wet_prod_ff <= del_x * wet_x;
         dry_prod_ff <= dry_x * dw_x;
         dry_ff      <= dry;
      end
   end

   always_comb begin
      fb_term = round_sat(fb_prod_ff);
      wr_data = sat_add(dry_ff, fb_term);
      y       = round_sat(dry_prod_ff + wet_prod_ff);
   end

endmodule

// ----- rtl/stereo_feedback_delay.sv -----
// top level of the stereo feedback delay: control, ring memory and output register
//
// channel  dir  handshake               payload
// req      in   req_tvalid/req_tready   req_tdata: left_in, right_in
// rsp      out  rsp_tvalid/rsp_tready   rsp_tdata: left_out, right_out
// csr      in   csr_valid/csr_ready     csr_index, csr_wdata
//
// one ring read at accept, one write as a frame leaves s2; accept needs an empty s1
// rsp_tvalid rises together with the ring write, as the frame leaves s2
// after reset all LINE_DEPTH (131072) ring entries are zeroed, one entry per cycle,
// with req_tready low; csr writes are taken at any time
// a stalled rsp holds the pipeline; a frame waiting in rsp lets the next get only to s2
`include "stereo_feedback_delay_macros.svh"

module stereo_feedback_delay (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sfd_pkg::BUS_W-1:0]     req_tdata,   // left_in, right_in
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sfd_pkg::BUS_W-1:0]     rsp_tdata,   // left_out, right_out
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sfd_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [sfd_pkg::DELAY_W-1:0]   csr_wdata
);
   import sfd_pkg::*;

   logic [DELAY_W-1:0] delay_ff;
   logic [FB_W-1:0]    fb_ff;
   logic [MIX_W-1:0]   mix_ff;

   logic               clear_ff;
   logic               clear_in;
   logic [PTR_W-1:0]   clr_addr_ff;
   logic [PTR_W-1:0]   clr_addr_in;
   logic [PTR_W-1:0]   wp_ff;
   logic [PTR_W-1:0]   wp_in;

   logic               s1_v_ff;
   logic               s1_v_in;
   logic [PTR_W-1:0]   s1_addr_ff;
   sample_type         s1_dry_ff [CHANNELS];
   logic               fwd_v_ff;
   logic [WORD_W-1:0]  fwd_word_ff;
   logic               s2_v_ff;
   logic               s2_v_in;
   logic [PTR_W-1:0]   s2_addr_ff;
   logic               out_v_ff;
   logic               out_v_in;
   logic [WORD_W-1:0]  out_word_ff;

   logic               accept;
   logic               s1_go;
   logic               s2_go;
   logic [PTR_W-1:0]   rp;
   logic [CALC_W-1:0]  d_x;
   logic [CALC_W-1:0]  wp_x;
   logic [MIX_W-1:0]   mix_eff;
   gain_type           gain;

   logic               ram_we;
   logic [PTR_W-1:0]   ram_waddr;
   logic [WORD_W-1:0]  ram_wdata;
   logic [WORD_W-1:0]  ram_q;
   logic [WORD_W-1:0]  del_word;
   logic [WORD_W-1:0]  wr_word;
   logic [WORD_W-1:0]  y_word;
   sample_type         wr_lane [CHANNELS];
   sample_type         y_lane [CHANNELS];

   // csr writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DELAY_RESET;
         fb_ff    <= FB_RESET;
         mix_ff   <= MIX_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_DELAY:    delay_ff <= csr_wdata;
            REG_FEEDBACK: fb_ff    <= csr_wdata[FB_W-1:0];
            REG_MIX:      mix_ff   <= csr_wdata[MIX_W-1:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      mix_eff      = (mix_ff > MIX_ONE) ? MIX_ONE : mix_ff;
      gain.fb_gain = fb_ff;
      gain.mix     = mix_eff;
   end

   // read position delay_ff entries behind the write pointer, or at it when the delay is zero
   always_comb begin
      d_x  = CALC_W'(delay_ff);
      wp_x = CALC_W'(wp_ff);
      if (d_x == '0 || d_x >= CALC_W'(LINE_DEPTH)) begin
         rp = wp_ff;
      end else if (wp_x >= d_x) begin
         rp = PTR_W'(wp_x - d_x);
      end else begin
         rp = PTR_W'(wp_x + CALC_W'(LINE_DEPTH) - d_x);
      end
   end

   // pipeline control
   always_comb begin
      s2_go      = s2_v_ff & (~out_v_ff | rsp_tready);
      s1_go      = s1_v_ff & (~s2_v_ff | s2_go);
      req_tready = ~clear_ff & ~s1_v_ff & (~s2_v_ff | s2_go);
      accept     = req_tvalid & req_tready;
      s1_v_in    = accept | (s1_v_ff & ~s1_go);
      s2_v_in    = s1_go | (s2_v_ff & ~s2_go);
      out_v_in   = s2_go | (out_v_ff & ~rsp_tready);
      wp_in      = wp_ff;
      if (accept) begin
         wp_in = (wp_ff == LAST_PTR) ? '0 : wp_ff + 1'b1;
      end
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_PTR) begin
            clear_in    = 1'b0;
            clr_addr_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
         wp_ff       <= '0;
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         out_v_ff    <= 1'b0;
      end else begin
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
         wp_ff       <= wp_in;
         s1_v_ff     <= s1_v_in;
         s2_v_ff     <= s2_v_in;
         out_v_ff    <= out_v_in;
      end
   end

   // payload of the stages
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff  <= wp_ff;
         fwd_v_ff    <= s2_go && (s2_addr_ff == rp);
         fwd_word_ff <= wr_word;
         for (int c = 0; c < CHANNELS; c++) begin
            s1_dry_ff[c] <= sample_type'(req_tdata[c*SAMPLE_W +: SAMPLE_W]);
         end
      end
      if (s1_go) begin
         s2_addr_ff <= s1_addr_ff;
      end
      if (s2_go) begin
         out_word_ff <= y_word;
      end
   end

   // ring memory, both channels side by side in one word
   always_comb begin
      ram_we    = clear_ff | s2_go;
      ram_waddr = clear_ff ? clr_addr_ff : s2_addr_ff;
      ram_wdata = clear_ff ? '0 : wr_word;
      del_word  = fwd_v_ff ? fwd_word_ff : ram_q;
   end

   sfd_ram #(
      .DEPTH (LINE_DEPTH),
      .WIDTH (WORD_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (rp),
      .rd_data (ram_q)
   );

   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
      sfd_lane u_lane (
         .clock   (clock),
         .load    (s1_go),
         .dry     (s1_dry_ff[ch]),
         .del     (sample_type'(del_word[ch*SAMPLE_W +: SAMPLE_W])),
         .gain    (gain),
         .wr_data (wr_lane[ch]),
         .y       (y_lane[ch])
      );
   end

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         wr_word[c*SAMPLE_W +: SAMPLE_W] = wr_lane[c];
         y_word[c*SAMPLE_W +: SAMPLE_W]  = y_lane[c];
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = BUS_W'(out_word_ff);

   `SFD_ASSERT_NOW(a_no_accept_in_clear, clock, reset, clear_ff, !req_tready)
   `SFD_ASSERT_NOW(a_single_frame_in_flight, clock, reset, s1_v_ff, !s2_v_ff)
   `SFD_ASSERT_NEXT(a_ptr_advance, clock, reset, accept && wp_ff != LAST_PTR, wp_ff == $past(wp_ff) + 1'b1)
   `SFD_ASSERT_NEXT(a_write_lands_in_rsp, clock, reset, s2_go, out_v_ff && !s2_v_ff)

endmodule

// ----- test/sfd_echo_check.sv -----
// checker for the stereo feedback delay: echo predictor and beat-by-beat result compare
`timescale 1ns / 100ps

module sfd_echo_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [sfd_pkg::BUS_W-1:0]     req_tdata,   // left_in, right_in
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [sfd_pkg::BUS_W-1:0]     rsp_tdata,   // left_out, right_out
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [sfd_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [sfd_pkg::DELAY_W-1:0]   csr_wdata,
   output int                            fail_count,
   output int                            pending_count
);
   import sfd_pkg::*;

   typedef struct packed {
      sample_type right_s;
      sample_type left_s;
   } stereo_frame;

   bit signed [SAMPLE_W-1:0] ring_mem [CHANNELS][LINE_DEPTH];
   int unsigned              wr_ptr;
   bit [DELAY_W-1:0]         delay_reg;
   bit [FB_W-1:0]            feedback_reg;
   bit [MIX_W-1:0]           mix_reg;
   stereo_frame              wet_frames_q[$];
   int                       mismatch_total;

   assign fail_count = mismatch_total;

   function automatic sample_type clamp16(input longint v);
      if (v > 32767) begin
         return 16'sh7fff;
      end else if (v < -32768) begin
         return 16'sh8000;
      end
      return sample_type'(v);
   endfunction

   // round half up then floor shift by 15
   function automatic sample_type round_q15(input longint acc);
      longint q;
      q = (acc + 64'sd16384) >>> 15;
      return clamp16(q);
   endfunction

   task automatic echo_step(input stereo_frame dry_in, output stereo_frame wet_out);
      int unsigned span;
      int unsigned rd_ptr;
      longint      wet_share;
      longint      gain;
      longint      dry;
      longint      tap;
      sample_type  fed;
      sample_type  mixed;
      span      = (delay_reg > LINE_DEPTH) ? LINE_DEPTH : delay_reg;
      wet_share = (mix_reg > MIX_ONE) ? longint'(MIX_ONE) : longint'(mix_reg);
      gain      = longint'(feedback_reg);
      rd_ptr    = (wr_ptr + LINE_DEPTH - span) % LINE_DEPTH;
      wet_out   = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         dry   = (ch == 0) ? longint'(dry_in.left_s) : longint'(dry_in.right_s);
         tap   = longint'(ring_mem[ch][rd_ptr]);
         fed   = clamp16(dry + longint'(round_q15(tap * gain)));
         mixed = round_q15(dry * (64'sd32768 - wet_share) + tap * wet_share);
         ring_mem[ch][wr_ptr] = fed;
         if (ch == 0) begin
            wet_out.left_s = mixed;
         end else begin
            wet_out.right_s = mixed;
         end
      end
      wr_ptr = (wr_ptr + 1) % LINE_DEPTH;
   endtask

   task automatic report_mismatch(input string msg);
      if (mismatch_total < 100) begin
         $display("%0t mismatch: %s", $realtime, msg);
      end
      mismatch_total++;
   endtask

   initial begin
      mismatch_total = 0;
   end

   always @(posedge clock) begin
      stereo_frame got;
      stereo_frame want;
      if (reset) begin
         foreach (ring_mem[c, i]) begin
            ring_mem[c][i] = '0;
         end
         wr_ptr        = 0;
         delay_reg     = DELAY_RESET;
         feedback_reg  = FB_RESET;
         mix_reg       = MIX_RESET;
         wet_frames_q.delete();
         pending_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DELAY:    delay_reg    = csr_wdata[DELAY_W-1:0];
               REG_FEEDBACK: feedback_reg = csr_wdata[FB_W-1:0];
               REG_MIX:      mix_reg      = csr_wdata[MIX_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = stereo_frame'(rsp_tdata);
            if (wet_frames_q.size() == 0) begin
               report_mismatch($sformatf("result beat %h with nothing pending", rsp_tdata));
            end else begin
               want = wet_frames_q.pop_front();
               if (got.left_s !== want.left_s) begin
                  report_mismatch($sformatf("left_out got %0d want %0d",
                                            got.left_s, want.left_s));
               end
               if (got.right_s !== want.right_s) begin
                  report_mismatch($sformatf("right_out got %0d want %0d",
                                            got.right_s, want.right_s));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            echo_step(stereo_frame'(req_tdata), want);
            wet_frames_q.push_back(want);
         end
         pending_count <= wet_frames_q.size();
      end
   end

endmodule

// ----- test/tb_stereo_feedback_delay.sv -----
// testbench top for the stereo feedback delay: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_stereo_feedback_delay;
   import sfd_pkg::*;

   localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
   localparam sample_type PEAK_HI = 16'sh7fff;
   localparam sample_type PEAK_LO = 16'sh8000;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [BUS_W-1:0]     req_tdata;   // left_in, right_in
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [BUS_W-1:0]     rsp_tdata;   // left_out, right_out
   logic                 csr_valid;
   logic                 csr_ready;
   logic [REG_IDX_W-1:0] csr_index;
   logic [DELAY_W-1:0]   csr_wdata;
   int                   fail_count;
   int                   pending_count;

   stereo_feedback_delay dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   sfd_echo_check u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1200000;
      $display("tb: failure");
      $finish;
   end

   // receiver: stall rate redrawn from 0, 30, 60 or 90 percent over random spans, one long hold-off mid run
   initial begin
      int stall_pct;
      int span;
      int hold_left;
      int taken;
      bit hold_done;
      rsp_tready <= 1'b0;
      stall_pct = 0;
      span      = 0;
      hold_left = 0;
      taken     = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) taken++;
         if (!hold_done && taken >= 560) begin
            hold_done = 1'b1;
            hold_left = 300;
         end
         if (span == 0) begin
            span = $urandom_range(10, 80);
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 30;
               2: stall_pct = 60;
               default: stall_pct = 90;
            endcase
         end
         span--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 9))
         0: return PEAK_HI;
         1: return PEAK_LO;
         2: return '0;
         default: return sample_type'($urandom());
      endcase
   endfunction

   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_params(input logic [DELAY_W-1:0] delay_v, input logic [FB_W-1:0] gain_v,
                             input logic [MIX_W-1:0] mix_v);
      write_reg(REG_DELAY, delay_v);
      write_reg(REG_FEEDBACK, {2'($urandom_range(0, 3)), gain_v});
      write_reg(REG_MIX, {1'($urandom_range(0, 1)), mix_v});
      write_reg(REG_SPARE, DELAY_W'($urandom()));
      csr_valid <= 1'b0;
   endtask

   task automatic send_frame(input sample_type left_s, input sample_type right_s);
      req_tvalid <= 1'b1;
      req_tdata  <= {right_s, left_s};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic run_frames(input int count);
      int sent;
      int burst;
      int gap;
      sent = 0;
      while (sent < count) begin
         burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
         for (int k = 0; k < burst && sent < count; k++) begin
            send_frame(pick_sample(), pick_sample());
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // stop offering and wait until every beat in flight has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      logic [DELAY_W-1:0] delay_v;
      logic [FB_W-1:0]    gain_v;
      logic [MIX_W-1:0]   mix_v;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= REG_DELAY;
      csr_wdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // one-sample echo at full feedback: store saturates
      set_params(DELAY_W'(1), FB_W'(32767), MIX_W'(16384));
      send_frame(PEAK_HI, PEAK_LO);
      send_frame(PEAK_HI, PEAK_LO);
      send_frame(PEAK_HI, PEAK_LO);
      send_frame(PEAK_LO, PEAK_HI);
      send_frame(16'sd0, 16'sd0);
      send_frame(-16'sd1, 16'sd1);
      send_frame(16'sd1, -16'sd1);
      send_frame(16'sd16384, -16'sd16384);
      settle();

      // zero delay, no feedback, mix above one
      set_params(DELAY_W'(0), FB_W'(0), MIX_W'(65535));
      send_frame(16'sd12345, -16'sd12345);
      send_frame(PEAK_HI, PEAK_LO);
      send_frame(-16'sd1, -16'sd1);
      send_frame(16'sd0, 16'sd0);
      settle();

      // longest delay, fully dry
      set_params(DELAY_W'(131071), FB_W'(1), MIX_W'(0));
      send_frame(PEAK_LO, PEAK_LO);
      send_frame(PEAK_HI, PEAK_HI);
      send_frame(16'sd256, -16'sd256);
      send_frame(-16'sd2, 16'sd2);
      settle();

      // fully wet, two-sample echo
      set_params(DELAY_W'(2), FB_W'(32767), MIX_ONE);
      send_frame(PEAK_HI, PEAK_LO);
      send_frame(PEAK_LO, PEAK_HI);
      send_frame(16'sd100, -16'sd100);
      send_frame(PEAK_HI, PEAK_HI);
      send_frame(PEAK_LO, PEAK_LO);
      settle();

      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(0, 9))
            0: delay_v = '0;
            1: delay_v = DELAY_W'(131071);
            2: delay_v = DELAY_W'($urandom_range(0, 131071));
            default: delay_v = DELAY_W'($urandom_range(1, 150));
         endcase
         case ($urandom_range(0, 5))
            0: gain_v = '0;
            1: gain_v = FB_W'(32767);
            default: gain_v = FB_W'($urandom_range(0, 32767));
         endcase
         case ($urandom_range(0, 5))
            0: mix_v = '0;
            1: mix_v = MIX_ONE;
            2: mix_v = MIX_W'($urandom_range(32769, 65535));
            default: mix_v = MIX_W'($urandom_range(0, 32768));
         endcase
         set_params(delay_v, gain_v, mix_v);
         run_frames(160);
         settle();
      end

      repeat (6) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
